// ===== rtl/core/jog_shuttle_packet_decoder_defines.svh =====
// ---------------------------------------------------------------------------
// Jog/shuttle packet decoder assertion macros
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef JOG_SHUTTLE_PACKET_DECODER_DEFINES_SVH
`define JOG_SHUTTLE_PACKET_DECODER_DEFINES_SVH

`ifndef SYNTH

// Check a property outside reset
`define JSD_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("jsd: property violated");

// Check a property at every edge, reset included
`define JSD_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("jsd: property violated");

`else

`define JSD_ASSERT(label, clk, rst, prop)
`define JSD_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== rtl/core/jsd_pkg.sv =====
// ---------------------------------------------------------------------------
// Jog/shuttle packet decoder package
// Shared types, protocol bytes and wheel decode tables.
// ---------------------------------------------------------------------------
package jsd_pkg;

  // Protocol bytes
  localparam logic [7:0] START_BYTE  = 8'h07;
  localparam logic [7:0] HEADER_BYTE = 8'h03;

  // Parser positions: idle, then index of the next packet byte plus one
  localparam logic [2:0] POS_IDLE = 3'd0;
  localparam logic [2:0] POS_LAST = 3'd4;

  // Inner wheel lock code and step count limit
  localparam logic [1:0]        LOCK_CODE = 2'd3;
  localparam logic signed [7:0] CNT_MAX   = 8'sd127;

  typedef enum logic [1:0] {
    EV_BUTTON = 2'd0,
    EV_LOCK   = 2'd1,
    EV_SPEED  = 2'd2
  } event_kind_t;

  // Completed packet handed from parser to decoder
  typedef struct packed {
    logic       go;
    logic [7:0] wheel;
    logic [7:0] keys;
  } pkt_t;

  // Set of events from one packet; pending is {buttons 6..0, lock, speed}
  typedef struct packed {
    logic [8:0]        pending;
    logic [6:0]        keys;
    logic [6:0]        old_keys;
    logic signed [1:0] dir;
    logic [31:0]       hist;
    logic signed [3:0] speed;
    logic signed [3:0] prev_speed;
  } evset_t;

  // Clockwise history pattern for the newest inner code
  function automatic logic [15:0] right_pattern(input logic [1:0] code);
    logic [15:0] r;
    unique case (code)
      2'd0:    r = 16'h1320;
      2'd1:    r = 16'h3201;
      2'd2:    r = 16'h0132;
      default: r = 16'h2013;
    endcase
    return r;
  endfunction

  // Anticlockwise history pattern for the newest inner code
  function automatic logic [15:0] left_pattern(input logic [1:0] code);
    logic [15:0] r;
    unique case (code)
      2'd0:    r = 16'h2310;
      2'd1:    r = 16'h0231;
      2'd2:    r = 16'h3102;
      default: r = 16'h1023;
    endcase
    return r;
  endfunction

  // Outer ring code to shuttle speed
  function automatic logic signed [3:0] speed_of(input logic [3:0] code);
    logic signed [3:0] s;
    unique case (code)
      4'd0:    s = -4'sd5;
      4'd1:    s = 4'sd5;
      4'd2:    s = -4'sd6;
      4'd3:    s = 4'sd6;
      4'd4:    s = -4'sd4;
      4'd5:    s = 4'sd4;
      4'd6:    s = -4'sd7;
      4'd7:    s = 4'sd7;
      4'd8:    s = -4'sd2;
      4'd9:    s = 4'sd2;
      4'd10:   s = -4'sd1;
      4'd11:   s = 4'sd1;
      4'd12:   s = -4'sd3;
      4'd13:   s = 4'sd3;
      default: s = 4'sd0;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/core/jsd_parser.sv =====
// ---------------------------------------------------------------------------
// Jog/shuttle packet parser
// Frames received bytes into packets and flags completed good packets.
// ---------------------------------------------------------------------------
`include "jog_shuttle_packet_decoder_defines.svh"

module jsd_parser
  import jsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  input  logic       can_load,
  output pkt_t       pkt
);

  logic [2:0] pos;
  logic [2:0] pos_next;
  logic [7:0] pkt_bytes [3];
  logic [1:0] wr_idx;
  logic       accept;

  // Hold the check byte while the previous event set is still draining
  assign rx_stall = (pos == POS_LAST) && !can_load;
  assign accept   = rx_valid && !rx_stall;
  assign wr_idx   = pos[1:0] - 2'd1;

  // Advance the byte position
  always_comb begin
    pos_next = pos;
    if (accept) begin
      priority if (pos == POS_IDLE) begin
        if (rx_byte == START_BYTE) begin
          pos_next = 3'd1;
        end
      end else if (pos == POS_LAST) begin
        pos_next = POS_IDLE;
      end else begin
        pos_next = pos + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_IDLE;
    end else begin
      pos <= pos_next;
    end
  end

  // Store header, wheel and key bytes
  always_ff @(posedge clk) begin
    if (accept && pos != POS_IDLE && pos != POS_LAST) begin
      pkt_bytes[wr_idx] <= rx_byte;
    end
  end

  // Flag a complete packet with a good header; drop anything else
  assign pkt.go    = accept && (pos == POS_LAST) && (pkt_bytes[0] == HEADER_BYTE);
  assign pkt.wheel = pkt_bytes[1];
  assign pkt.keys  = pkt_bytes[2];

  `JSD_ASSERT(a_idle_drop, clk, rst,
    (accept && pos == POS_IDLE && rx_byte != START_BYTE) |=> (pos == POS_IDLE))

endmodule

// ===== rtl/core/jsd_decoder.sv =====
// ---------------------------------------------------------------------------
// Jog/shuttle packet decoder core
// Tracks key, wheel and history state and builds the event set of a packet.
// ---------------------------------------------------------------------------
`include "jog_shuttle_packet_decoder_defines.svh"

module jsd_decoder
  import jsd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  pkt_t   pkt,
  output evset_t evs
);

  logic [6:0]        prev_keys;
  logic [1:0]        prev_inner;
  logic [3:0]        prev_outer;
  logic [31:0]       hist;
  logic signed [7:0] cnt;

  logic [6:0]        keys;
  logic [1:0]        inner;
  logic [3:0]        outer;
  logic              inner_chg;
  logic              lock;
  logic [31:0]       hist_next;
  logic signed [7:0] cnt_step;
  logic signed [7:0] cnt_next;
  logic signed [1:0] dir;

  // Unpack the packet and build the event set
  always_comb begin
    keys      = ~pkt.keys[7:1];
    inner     = pkt.wheel[7:6];
    outer     = pkt.wheel[5:2];
    inner_chg = (inner != prev_inner);
    hist_next = inner_chg ? {hist[27:0], 2'b00, inner} : hist;

    // Count direction on a matching history, saturating
    cnt_step = cnt;
    if (inner_chg) begin
      priority if (hist_next[15:0] == right_pattern(inner)) begin
        if (cnt != CNT_MAX) begin
          cnt_step = cnt + 8'sd1;
        end
      end else if (hist_next[15:0] == left_pattern(inner)) begin
        if (cnt != -CNT_MAX) begin
          cnt_step = cnt - 8'sd1;
        end
      end else begin
        cnt_step = cnt;
      end
    end

    // Resolve the direction at the lock position
    lock     = inner_chg && (inner == LOCK_CODE);
    dir      = (cnt_step > 8'sd0) ? 2'sd1 : -2'sd1;
    cnt_next = lock ? {{6{dir[1]}}, dir} : cnt_step;

    evs.pending    = {keys ^ prev_keys, lock, outer != prev_outer};
    evs.keys       = keys;
    evs.old_keys   = prev_keys;
    evs.dir        = dir;
    evs.hist       = hist_next;
    evs.speed      = speed_of(outer);
    evs.prev_speed = speed_of(prev_outer);
  end

  // Update the tracked state on each good packet
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_keys  <= '0;
      prev_inner <= LOCK_CODE;
      prev_outer <= 4'hf;
      hist       <= '0;
      cnt        <= '0;
    end else if (pkt.go) begin
      prev_keys  <= keys;
      prev_inner <= inner;
      prev_outer <= outer;
      hist       <= hist_next;
      cnt        <= cnt_next;
    end
  end

  `JSD_ASSERT(a_lock_unit, clk, rst,
    (pkt.go && lock) |=> (cnt == 8'sd1 || cnt == -8'sd1))

endmodule

// ===== rtl/core/jsd_emitter.sv =====
// ---------------------------------------------------------------------------
// Jog/shuttle event emitter
// Registers one packet's event set and hands out its events in order.
// ---------------------------------------------------------------------------
`include "jog_shuttle_packet_decoder_defines.svh"

module jsd_emitter
  import jsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  evset_t            evs_in,
  output logic              can_load,
  output logic              ev_valid,
  input  logic              ev_stall,
  output event_kind_t       event_kind,
  output logic [6:0]        button_bit,
  output logic              button_pressed,
  output logic [6:0]        key_mask,
  output logic [6:0]        old_key_mask,
  output logic signed [1:0] inner_direction,
  output logic [31:0]       inner_history,
  output logic signed [3:0] outer_speed,
  output logic signed [3:0] outer_old_speed,
  output logic              last_event
);

  evset_t     evs;
  logic [8:0] sel;
  logic [8:0] rest;
  logic       found;
  logic       take;
  logic       load;

  // Pick the highest pending event
  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int i = 8; i >= 0; i--) begin
      if (evs.pending[i] && !found) begin
        sel[i] = 1'b1;
        found  = 1'b1;
      end
    end
  end

  assign rest     = evs.pending & ~sel;
  assign ev_valid = |evs.pending;
  assign take     = ev_valid && !ev_stall;
  assign can_load = !ev_valid || (take && rest == '0);
  assign load     = go && (|evs_in.pending);

  // Load a new set, or drop the event just taken
  always_ff @(posedge clk) begin
    if (rst) begin
      evs.pending <= '0;
    end else if (load) begin
      evs <= evs_in;
    end else if (take) begin
      evs.pending <= rest;
    end
  end

  // Drive the fields of the current event
  always_comb begin
    event_kind      = EV_BUTTON;
    button_bit      = '0;
    button_pressed  = 1'b0;
    key_mask        = '0;
    old_key_mask    = '0;
    inner_direction = '0;
    inner_history   = '0;
    outer_speed     = '0;
    outer_old_speed = '0;
    priority if (sel[0]) begin
      event_kind      = EV_SPEED;
      outer_speed     = evs.speed;
      outer_old_speed = evs.prev_speed;
    end else if (sel[1]) begin
      event_kind      = EV_LOCK;
      inner_direction = evs.dir;
      inner_history   = evs.hist;
    end else begin
      button_bit     = sel[8:2];
      button_pressed = |(sel[8:2] & evs.keys);
      key_mask       = evs.keys;
      old_key_mask   = evs.old_keys;
    end
    last_event = (rest == '0);
  end

  `JSD_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !ev_valid)
  `JSD_ASSERT(a_more_follow, clk, rst, (take && rest != '0) |=> ev_valid)
  `JSD_ASSERT(a_load_free, clk, rst, load |-> can_load)

endmodule

// ===== rtl/core/jog_shuttle_packet_decoder.sv =====
// ---------------------------------------------------------------------------
// Jog/shuttle packet decoder
// Frames controller bytes into packets and turns key and wheel changes into
// button, lock step and speed events.
// ---------------------------------------------------------------------------
//  channel  handshake           payload
//  rx       rx_valid/rx_stall   rx_byte
//  ev       ev_valid/ev_stall   event_kind .. last_event, one event a request
//
//  One byte is taken per cycle unless rx stalls; a good packet is decoded as
//  its check byte is taken and its events appear on ev from the next cycle.
//  A packet gives zero to nine events, one per cycle while ev is not stalled,
//  set by the event register draining one event at a time.
//  rx stalls only on a check byte while the previous packet's events are
//  still waiting; it is released in the cycle the last one is taken.
//  Reset is synchronous; there is no clearing pass.
// ---------------------------------------------------------------------------
module jog_shuttle_packet_decoder
  import jsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              rx_valid,
  output logic              rx_stall,
  input  logic [7:0]        rx_byte,
  output logic              ev_valid,
  input  logic              ev_stall,
  output logic [1:0]        event_kind,
  output logic [6:0]        button_bit,
  output logic              button_pressed,
  output logic [6:0]        key_mask,
  output logic [6:0]        old_key_mask,
  output logic signed [1:0] inner_direction,
  output logic [31:0]       inner_history,
  output logic signed [3:0] outer_speed,
  output logic signed [3:0] outer_old_speed,
  output logic              last_event
);

  pkt_t        pkt;
  evset_t      evs;
  logic        can_load;
  event_kind_t kind;

  // Frame bytes into packets
  jsd_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .rx_byte  (rx_byte),
    .can_load (can_load),
    .pkt      (pkt)
  );

  // Decode a packet against the tracked state
  jsd_decoder u_decoder (
    .clk (clk),
    .rst (rst),
    .pkt (pkt),
    .evs (evs)
  );

  // Hand out the events
  jsd_emitter u_emitter (
    .clk             (clk),
    .rst             (rst),
    .go              (pkt.go),
    .evs_in          (evs),
    .can_load        (can_load),
    .ev_valid        (ev_valid),
    .ev_stall        (ev_stall),
    .event_kind      (kind),
    .button_bit      (button_bit),
    .button_pressed  (button_pressed),
    .key_mask        (key_mask),
    .old_key_mask    (old_key_mask),
    .inner_direction (inner_direction),
    .inner_history   (inner_history),
    .outer_speed     (outer_speed),
    .outer_old_speed (outer_old_speed),
    .last_event      (last_event)
  );

  assign event_kind = kind;

endmodule
